### hdl/rgb565_gradient_sampler_assert.svh
// Assertion macros for the gradient sampler checkers.
// Standalone header; included by any file that asserts.
`ifndef RGB565_GRADIENT_SAMPLER_ASSERT_SVH
`define RGB565_GRADIENT_SAMPLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSAMP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gradient sampler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GSAMP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gradient sampler check failed");

`endif

### hdl/gsamp_pkg.sv
// Shared constants, request type and colour widening functions
// for the gradient sampler. No dependencies.
`timescale 1ns / 1ps

package gsamp_pkg;

	localparam int MAX_POINTS = 16;
	localparam int FRAC_BITS  = 16;

	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W  = 5;
	localparam int IDX_W  = 4;
	localparam int COL_W  = 16;
	localparam int POS_W  = FRAC_BITS + 1;
	localparam int SCL_W  = POS_W + ADDR_W;
	localparam int CH_W   = 8;
	localparam int DIFF_W = CH_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
	localparam int SUM_W  = PROD_W;
	localparam int NUM_CH = 3;

	localparam int R_LSB = 11;
	localparam int G_LSB = 5;

	localparam logic [POS_W-1:0] ONE_FX = POS_W'(1) << FRAC_BITS;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_EVAL  = 1'b1
	} mode_t;

	typedef struct packed {
		logic                 evaluate;
		logic                 wr;
		logic [ADDR_W-1:0]    waddr;
		logic [COL_W-1:0]     wdata;
		logic [ADDR_W-1:0]    ia;
		logic [ADDR_W-1:0]    ib;
		logic [FRAC_BITS-1:0] frac;
	} req_t;

	function automatic logic [CH_W-1:0] widen5(input logic [4:0] v);
		logic [13:0] t;
		t = 14'(v) * 14'd527 + 14'd23;
		return t[13:6];
	endfunction

	function automatic logic [CH_W-1:0] widen6(input logic [5:0] v);
		logic [13:0] t;
		t = 14'(v) * 14'd259 + 14'd33;
		return t[13:6];
	endfunction

endpackage

### hdl/gsamp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gsamp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/gsamp_addr.sv
// Front stages: register the input word, clamp, scale the position and
// form point addresses and fraction. Depends on gsamp_pkg.
`timescale 1ns / 1ps

module gsamp_addr (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic [gsamp_pkg::IDX_W-1:0]       point_index,
	input  logic [gsamp_pkg::COL_W-1:0]       point_colour,
	input  logic [gsamp_pkg::POS_W-1:0]       position,
	input  logic [gsamp_pkg::CNT_W-1:0]       point_count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output gsamp_pkg::req_t                   out_req
);

	logic                              v_s1;
	logic                              mode_s1;
	logic [gsamp_pkg::IDX_W-1:0]       idx_s1;
	logic [gsamp_pkg::COL_W-1:0]       colour_s1;
	logic [gsamp_pkg::POS_W-1:0]       pos_s1;
	logic [gsamp_pkg::ADDR_W-1:0]      nm1_s1;
	logic                              v_s2;
	gsamp_pkg::req_t                   req_s2;

	logic                              rdy1;
	logic                              rdy2;
	logic [gsamp_pkg::POS_W-1:0]       pos_clamp;
	logic [gsamp_pkg::ADDR_W-1:0]      nm1;
	logic [gsamp_pkg::SCL_W-1:0]       scaled;
	logic [gsamp_pkg::ADDR_W-1:0]      ia;
	gsamp_pkg::req_t                   req_next;

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		pos_clamp = (position > gsamp_pkg::ONE_FX) ? gsamp_pkg::ONE_FX : position;
		priority if (point_count == '0) begin
			nm1 = '0;
		end else if (32'(point_count) > gsamp_pkg::MAX_POINTS) begin
			nm1 = gsamp_pkg::ADDR_W'(gsamp_pkg::MAX_POINTS - 1);
		end else begin
			nm1 = gsamp_pkg::ADDR_W'(point_count - 1'b1);
		end
	end

	always_comb begin
		scaled = gsamp_pkg::SCL_W'(pos_s1) * gsamp_pkg::SCL_W'(nm1_s1);
		ia     = scaled[gsamp_pkg::FRAC_BITS +: gsamp_pkg::ADDR_W];
		req_next.evaluate = (mode_s1 == gsamp_pkg::MODE_EVAL);
		req_next.wr       = (mode_s1 == gsamp_pkg::MODE_WRITE)
			&& (32'(idx_s1) < gsamp_pkg::MAX_POINTS);
		req_next.waddr    = gsamp_pkg::ADDR_W'(idx_s1);
		req_next.wdata    = colour_s1;
		req_next.ia       = ia;
		req_next.ib       = (ia == nm1_s1) ? '0 : gsamp_pkg::ADDR_W'(ia + 1'b1);
		req_next.frac     = scaled[gsamp_pkg::FRAC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			mode_s1   <= mode;
			idx_s1    <= point_index;
			colour_s1 <= point_colour;
			pos_s1    <= pos_clamp;
			nm1_s1    <= nm1;
		end
		if (rdy2 && v_s1) begin
			req_s2 <= req_next;
		end
	end

	assign out_valid = v_s2;
	assign out_req   = req_s2;

endmodule

### hdl/gsamp_mix.sv
// Back stages: widen both points to 8-bit channels, interpolate each
// channel and pack to RGB565 in the output register. Depends on gsamp_pkg.
`timescale 1ns / 1ps

module gsamp_mix (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [gsamp_pkg::FRAC_BITS-1:0]   in_frac,
	input  logic [gsamp_pkg::COL_W-1:0]       point_a,
	input  logic [gsamp_pkg::COL_W-1:0]       point_b,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gsamp_pkg::COL_W-1:0]       colour
);

	logic                                   v_s3;
	logic [gsamp_pkg::FRAC_BITS-1:0]        frac_s3;
	logic                                   v_s4;
	logic [gsamp_pkg::FRAC_BITS-1:0]        frac_s4;
	logic [gsamp_pkg::CH_W-1:0]             a_s4 [gsamp_pkg::NUM_CH];
	logic [gsamp_pkg::CH_W-1:0]             b_s4 [gsamp_pkg::NUM_CH];
	logic                                   v_s5;
	logic [gsamp_pkg::CH_W-1:0]             a_s5 [gsamp_pkg::NUM_CH];
	logic signed [gsamp_pkg::PROD_W-1:0]    prod_s5 [gsamp_pkg::NUM_CH];
	logic                                   v_s6;
	logic [gsamp_pkg::COL_W-1:0]            colour_s6;

	logic                                   rdy3;
	logic                                   rdy4;
	logic                                   rdy5;
	logic                                   rdy6;
	logic [gsamp_pkg::CH_W-1:0]             wa [gsamp_pkg::NUM_CH];
	logic [gsamp_pkg::CH_W-1:0]             wb [gsamp_pkg::NUM_CH];
	logic signed [gsamp_pkg::DIFF_W-1:0]    diff [gsamp_pkg::NUM_CH];
	logic signed [gsamp_pkg::PROD_W-1:0]    prod [gsamp_pkg::NUM_CH];
	logic signed [gsamp_pkg::SUM_W-1:0]     sum [gsamp_pkg::NUM_CH];
	logic [gsamp_pkg::CH_W-1:0]             ch [gsamp_pkg::NUM_CH];
	logic [gsamp_pkg::COL_W-1:0]            packed_colour;

	assign rdy6     = !v_s6 || out_ready;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign in_ready = rdy3;

	always_comb begin
		wa[0] = gsamp_pkg::widen5(point_a[gsamp_pkg::COL_W-1:gsamp_pkg::R_LSB]);
		wa[1] = gsamp_pkg::widen6(point_a[gsamp_pkg::R_LSB-1:gsamp_pkg::G_LSB]);
		wa[2] = gsamp_pkg::widen5(point_a[gsamp_pkg::G_LSB-1:0]);
		wb[0] = gsamp_pkg::widen5(point_b[gsamp_pkg::COL_W-1:gsamp_pkg::R_LSB]);
		wb[1] = gsamp_pkg::widen6(point_b[gsamp_pkg::R_LSB-1:gsamp_pkg::G_LSB]);
		wb[2] = gsamp_pkg::widen5(point_b[gsamp_pkg::G_LSB-1:0]);
	end

	always_comb begin
		for (int i = 0; i < gsamp_pkg::NUM_CH; i++) begin
			diff[i] = $signed({1'b0, b_s4[i]}) - $signed({1'b0, a_s4[i]});
			prod[i] = diff[i] * $signed({1'b0, frac_s4});
			sum[i]  = $signed({2'b00, a_s5[i], {gsamp_pkg::FRAC_BITS{1'b0}}}) + prod_s5[i];
			ch[i]   = sum[i][gsamp_pkg::FRAC_BITS +: gsamp_pkg::CH_W];
		end
		packed_colour = {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy3) begin
				v_s3 <= in_valid;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
			if (rdy6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && in_valid) begin
			frac_s3 <= in_frac;
		end
		if (rdy4 && v_s3) begin
			frac_s4 <= frac_s3;
			a_s4    <= wa;
			b_s4    <= wb;
		end
		if (rdy5 && v_s4) begin
			a_s5    <= a_s4;
			prod_s5 <= prod;
		end
		if (rdy6 && v_s5) begin
			colour_s6 <= packed_colour;
		end
	end

	assign out_valid = v_s6;
	assign colour    = colour_s6;

endmodule

### hdl/rgb565_gradient_sampler.sv
// Top level of the RGB565 gradient sampler: count register, point tables
// and the address and mix pipelines. Depends on gsamp_pkg, gsamp_addr,
// gsamp_ram and gsamp_mix.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tuser: mode; tdata: index, colour, position
//   m_axis    out  m_axis_tvalid/tready      tdata: colour
//   cfg       in   cfg_we                    cfg_wdata: point_count
//
// One word per clock in either mode while no stage stalls. An evaluate word
// reaches m_axis via s1, s2, the table read with s3, s4, s5 and s6; a write
// word retires on leaving the second stage, where it updates both point tables.
// Reset clears the stage valid bits and sets point_count to one; point
// tables hold nothing defined until written. On a stall each stage holds its
// word and empty stages close up behind it.
`timescale 1ns / 1ps

module rgb565_gradient_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [0:0]  s_axis_tuser,  // [0] mode
	input  logic [39:0] s_axis_tdata,  // [3:0] point_index, [19:4] point_colour,
	                                   // [36:20] position, [39:37] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] colour
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata      // point_count
);

	logic [gsamp_pkg::CNT_W-1:0]      point_count_q;
	logic                             req_valid;
	logic                             req_ready;
	gsamp_pkg::req_t                  req;
	logic                             tbl_we;
	logic [gsamp_pkg::COL_W-1:0]      point_a;
	logic [gsamp_pkg::COL_W-1:0]      point_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= gsamp_pkg::CNT_W'(1);
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	gsamp_addr u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.mode         (s_axis_tuser[0]),
		.point_index  (s_axis_tdata[3:0]),
		.point_colour (s_axis_tdata[19:4]),
		.position     (s_axis_tdata[36:20]),
		.point_count  (point_count_q),
		.out_valid    (req_valid),
		.out_ready    (req_ready),
		.out_req      (req)
	);

	assign tbl_we = req_ready && req_valid && req.wr;

	gsamp_ram #(
		.WIDTH (gsamp_pkg::COL_W),
		.DEPTH (gsamp_pkg::MAX_POINTS)
	) u_tbl_a (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.re    (req_ready),
		.raddr (req.ia),
		.rdata (point_a)
	);

	gsamp_ram #(
		.WIDTH (gsamp_pkg::COL_W),
		.DEPTH (gsamp_pkg::MAX_POINTS)
	) u_tbl_b (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.re    (req_ready),
		.raddr (req.ib),
		.rdata (point_b)
	);

	gsamp_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid && req.evaluate),
		.in_ready  (req_ready),
		.in_frac   (req.frac),
		.point_a   (point_a),
		.point_b   (point_b),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.colour    (m_axis_tdata)
	);

endmodule

### hdl/gsamp_checker.sv
// Port-level checks for the gradient sampler, bound to the top level.
// Depends on rgb565_gradient_sampler_assert.svh.
`timescale 1ns / 1ps
`include "rgb565_gradient_sampler_assert.svh"

module gsamp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	`GSAMP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`GSAMP_ASSERT_NOW(a_empty_out_takes, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`GSAMP_ASSERT_NOW(a_drain_takes, clk, arst_n, m_axis_tready, s_axis_tready)
	`GSAMP_ASSERT_NEXT(a_no_early_out, clk, arst_n, $rose(arst_n), !m_axis_tvalid)

endmodule

bind rgb565_gradient_sampler gsamp_checker u_gsamp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### dv/gradient_colour_checker.sv
// Colour checker for the RGB565 gradient sampler: predicts each evaluate word
// from its own point table and count register and compares the output stream.
// Depends on gsamp_pkg.
`timescale 1ns / 1ps

module gradient_colour_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [0:0]  s_axis_tuser,  // [0] mode
	input  logic [39:0] s_axis_tdata,  // [3:0] point_index, [19:4] point_colour,
	                                   // [36:20] position, [39:37] zero
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // [15:0] colour
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,     // point_count
	output int          pending,
	output int          failures
);

	logic [15:0] gradient_points [gsamp_pkg::MAX_POINTS];
	logic [4:0]  count_reg;
	logic [15:0] expected_colours [$];
	logic [15:0] want;

	function automatic longint unsigned expand_channel(longint unsigned v,
	                                                    longint unsigned mul,
	                                                    longint unsigned add);
		return (v * mul + add) >> 6;
	endfunction

	function automatic logic [7:0] mix_channel(longint unsigned a, longint unsigned b,
	                                           longint unsigned frac);
		longint unsigned one;
		one = longint'(gsamp_pkg::ONE_FX);
		return 8'((a * (one - frac) + b * frac) >> gsamp_pkg::FRAC_BITS);
	endfunction

	function automatic logic [15:0] blend_colour(logic [16:0] pos);
		longint unsigned n, p, scaled, frac, ia, ib;
		logic [15:0] ca, cb;
		logic [7:0]  r, g, b;
		n = count_reg;
		if (n == 0)
			n = 1;
		if (n > gsamp_pkg::MAX_POINTS)
			n = gsamp_pkg::MAX_POINTS;
		p = pos;
		if (p > longint'(gsamp_pkg::ONE_FX))
			p = longint'(gsamp_pkg::ONE_FX);
		scaled = p * (n - 1);
		ia = (scaled >> gsamp_pkg::FRAC_BITS) % n;
		frac = scaled & (longint'(gsamp_pkg::ONE_FX) - 1);
		ib = (ia + 1) % n;
		ca = gradient_points[ia];
		cb = gradient_points[ib];
		r = mix_channel(expand_channel(ca[15:11], 527, 23),
		                expand_channel(cb[15:11], 527, 23), frac);
		g = mix_channel(expand_channel(ca[10:5], 259, 33),
		                expand_channel(cb[10:5], 259, 33), frac);
		b = mix_channel(expand_channel(ca[4:0], 527, 23),
		                expand_channel(cb[4:0], 527, 23), frac);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			count_reg = 5'd1;
			expected_colours.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_colours.size() == 0) begin
					failures++;
					$display("%0t: colour %h with none expected", $time, m_axis_tdata);
				end else begin
					want = expected_colours.pop_front();
					if (m_axis_tdata !== want) begin
						failures++;
						$display("%0t: colour mismatch, expected %h, actual %h",
						         $time, want, m_axis_tdata);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (gsamp_pkg::mode_t'(s_axis_tuser[0]) == gsamp_pkg::MODE_WRITE)
					gradient_points[s_axis_tdata[3:0]] = s_axis_tdata[19:4];
				else
					expected_colours.push_back(blend_colour(s_axis_tdata[36:20]));
			end
			if (cfg_we)
				count_reg = cfg_wdata;
			pending <= expected_colours.size();
		end
	end

endmodule

### dv/rgb565_gradient_sampler_test.sv
// Testbench top for the RGB565 gradient sampler: drives point writes, evaluate
// words and count settings, and gives the verdict from gradient_colour_checker.
// Depends on gsamp_pkg, the sampler RTL and the checker.
`timescale 1ns / 1ps

module rgb565_gradient_sampler_test;

	localparam int WORD_TARGET     = 1850;
	localparam int SETTLE_CYCLES   = 12;
	localparam int HOLD_OFF_CYCLES = 240;
	localparam int WATCHDOG_LIMIT  = 2000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [0:0]  s_axis_tuser;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;

	int pending;
	int failures;
	int stalled_cycles;
	int word_total;
	int count_now;
	bit calm;
	bit hold_off_req;
	bit hold_off_done;

	int count_plan [7] = '{16, 2, 1, 0, 17, 31, 3};

	rgb565_gradient_sampler i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	gradient_colour_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.pending       (pending),
		.failures      (failures)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic push_word(gsamp_pkg::mode_t mode, logic [3:0] slot,
	                         logic [15:0] colour, logic [16:0] pos);
		if (!calm && $urandom_range(99) < 7) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {3'b000, pos, colour, slot};
		do @(posedge clk); while (!s_axis_tready);
		word_total++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_count(int value);
		cfg_we    <= 1'b1;
		cfg_wdata <= 5'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		count_now = value;
	endtask

	function automatic logic [16:0] pick_position();
		int seg, k, p;
		seg = count_now;
		if (seg == 0)
			seg = 1;
		if (seg > gsamp_pkg::MAX_POINTS)
			seg = gsamp_pkg::MAX_POINTS;
		seg = seg - 1;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: p = $urandom_range(0, 65536);
			5, 6:          p = $urandom_range(0, 131071);
			7: begin
				case ($urandom_range(5))
					0: p = 0;
					1: p = 1;
					2: p = 65535;
					3: p = 65536;
					4: p = 65537;
					default: p = 131071;
				endcase
			end
			default: begin
				if (seg == 0) begin
					p = $urandom_range(0, 131071);
				end else begin
					k = $urandom_range(0, seg);
					p = (k * 65536) / seg + $urandom_range(0, 4) - 2;
					if (p < 0)
						p = 0;
				end
			end
		endcase
		return 17'(p);
	endfunction

	function automatic logic [15:0] pick_colour();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hF800;
			3: return 16'h07E0;
			4: return 16'h001F;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		m_axis_tready <= 1'b0;
		hold_off_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			m_axis_tready <= calm || $urandom_range(99) >= 7;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			stalled_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	initial begin
		int phase, len;
		logic [15:0] corners [5];
		corners = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F};
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser  <= gsamp_pkg::MODE_WRITE;
		s_axis_tdata  <= '0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		word_total = 0;
		count_now = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < gsamp_pkg::MAX_POINTS; i++)
			push_word(gsamp_pkg::MODE_WRITE, 4'(i), i < 5 ? corners[i] : 16'($urandom),
			          17'($urandom));
		push_word(gsamp_pkg::MODE_EVAL, 4'hF, 16'hFFFF, 17'h00000);
		push_word(gsamp_pkg::MODE_EVAL, 4'h0, 16'h0000, 17'h1FFFF);
		drain();
		load_count(16);
		push_word(gsamp_pkg::MODE_EVAL, 4'($urandom), 16'($urandom), 17'h10000);
		push_word(gsamp_pkg::MODE_EVAL, 4'($urandom), 16'($urandom), 17'h0FFFF);
		push_word(gsamp_pkg::MODE_EVAL, 4'($urandom), 16'($urandom), 17'h08000);
		drain();
		load_count(0);
		push_word(gsamp_pkg::MODE_EVAL, 4'($urandom), 16'($urandom), 17'h1FFFF);
		drain();
		load_count(31);
		push_word(gsamp_pkg::MODE_EVAL, 4'($urandom), 16'($urandom), 17'h10001);
		push_word(gsamp_pkg::MODE_EVAL, 4'($urandom), 16'($urandom), 17'h00001);

		phase = 0;
		while (word_total < WORD_TARGET) begin
			drain();
			load_count(phase < 7 ? count_plan[phase] : $urandom_range(0, 31));
			calm = (phase == 5);
			if (phase == 2)
				hold_off_req = 1'b1;
			len = $urandom_range(60, 180);
			for (int w = 0; w < len; w++) begin
				if ($urandom_range(3) == 0)
					push_word(gsamp_pkg::MODE_WRITE, 4'($urandom), pick_colour(),
					          17'($urandom));
				else
					push_word(gsamp_pkg::MODE_EVAL, 4'($urandom), 16'($urandom),
					          pick_position());
			end
			phase++;
		end
		calm = 1'b0;
		drain();

		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### rgb565_gradient_sampler.f
+incdir+hdl
hdl/gsamp_pkg.sv
hdl/gsamp_ram.sv
hdl/gsamp_addr.sv
hdl/gsamp_mix.sv
hdl/rgb565_gradient_sampler.sv
hdl/gsamp_checker.sv
dv/gradient_colour_checker.sv
dv/rgb565_gradient_sampler_test.sv
